>>> rtl/htrlu_pkg.sv
package htrlu_pkg;

    // input actions
    localparam logic [1:0] ACT_START = 2'd0;
    localparam logic [1:0] ACT_LOAD  = 2'd1;
    localparam logic [1:0] ACT_CODE  = 2'd2;
    localparam logic [1:0] ACT_END   = 2'd3;

    // configuration register indexes
    localparam logic CFG_STRIP_CR = 1'b0;
    localparam logic CFG_EXPECTED = 1'b1;

    localparam logic [7:0] RLE_MARKER = 8'h90;
    localparam logic [7:0] CR_BYTE    = 8'h0D;

    // both children set to the end token, -(256 + 1) in 10 bits
    localparam logic [9:0]  END_CHILD = 10'h2FF;
    localparam logic [19:0] END_NODE  = {END_CHILD, END_CHILD};

    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic [1:0]  act;
        logic [7:0]  node_index;
        logic [19:0] node;        // {right, left} raw child codes
        logic [7:0]  code;
    } t_cmd;

    typedef struct packed {
        logic        strip_cr;
        logic [15:0] expected;
    } t_cfg;

endpackage

>>> rtl/htrlu_front.sv
module htrlu_front import htrlu_pkg::*; #(
    parameter int TREE_NODES = 256
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [1:0]        i_action,
    input  logic [7:0]        i_node_index,
    input  logic signed [9:0] i_left_child,
    input  logic signed [9:0] i_right_child,
    input  logic [7:0]        i_code_byte,
    output logic              o_q_valid,
    output t_cmd              o_q_cmd,
    input  logic              i_q_pop
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_cmd             r_q [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wp, r_rp;
    logic [CNT_W-1:0] r_cnt;

    logic w_accept, w_push, w_load_oor;
    t_cmd w_cmd;

    assign o_in_stall = (r_cnt == CNT_W'(QUEUE_DEPTH));
    assign w_accept   = i_in_valid && !o_in_stall;

    // loads outside the tree store are dropped here
    assign w_load_oor = (i_action == ACT_LOAD) &&
                        ({1'b0, i_node_index} >= 9'(TREE_NODES));
    assign w_push     = w_accept && !w_load_oor;

    always_comb begin
        w_cmd.act        = i_action;
        w_cmd.node_index = i_node_index;
        w_cmd.node       = {$unsigned(i_right_child), $unsigned(i_left_child)};
        w_cmd.code       = i_code_byte;
    end

    assign o_q_valid = (r_cnt != '0);
    assign o_q_cmd   = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wp <= (r_wp == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (i_q_pop) begin
                r_rp <= (r_rp == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (w_push && !i_q_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!w_push && i_q_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

`ifndef ASSERT_OFF
    a_empty_ptrs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == '0) |-> (r_wp == r_rp))
        else $error("queue empty with unequal pointers");
`endif

endmodule

>>> rtl/htrlu_back.sv
module htrlu_back import htrlu_pkg::*; #(
    parameter int TREE_NODES = 256
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cfg       i_cfg,
    input  logic       i_q_valid,
    input  t_cmd       i_q_cmd,
    output logic       o_q_pop,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_out_byte,
    output logic [7:0] o_copies,
    output logic       o_done_res,
    output logic       o_checksum_ok,
    output logic       o_last
);

    localparam int NODE_W = (TREE_NODES > 2) ? $clog2(TREE_NODES) : 1;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_WALK  = 2'd1;
    localparam logic [1:0] S_FLUSH = 2'd2;
    localparam logic [1:0] S_DONE  = 2'd3;

    logic [19:0] r_mem [TREE_NODES];
    logic [19:0] r_rd_data;

    logic [1:0]        r_state, n_state;
    logic [NODE_W-1:0] r_pos, n_pos;
    logic [7:0]        r_prev, n_prev;
    logic              r_await, n_await;
    logic [15:0]       r_sum, n_sum;
    logic              r_fin, n_fin;
    logic [2:0]        r_bit, n_bit;
    logic [7:0]        r_code, n_code;
    logic              r_ended, n_ended;
    logic              r_pend_valid, n_pend_valid;
    logic [7:0]        r_pend_byte, n_pend_byte;
    logic [7:0]        r_pend_copies, n_pend_copies;

    logic              r_out_valid;
    logic [7:0]        r_out_byte, r_out_copies;
    logic              r_out_done, r_out_ok, r_out_last;

    logic              w_mem_we, w_mem_re;
    logic [NODE_W-1:0] w_mem_waddr, w_mem_raddr;
    logic [19:0]       w_mem_wdata;

    logic              w_out_free, w_push;
    logic [7:0]        w_push_byte, w_push_copies;
    logic              w_push_done, w_push_ok, w_push_last;

    logic [9:0]        w_child, w_sym;
    logic              w_is_leaf, w_ended_now, w_leaf_ok;
    logic [NODE_W-1:0] w_next_pos;
    logic              w_run_valid, w_emit;
    logic [7:0]        w_run_byte, w_run_copies;
    logic              w_leaf_await;
    logic [7:0]        w_leaf_prev;
    logic [15:0]       w_prod;

    assign w_out_free = !r_out_valid || !i_out_stall;

    // one tree step: pick the child for the current code bit
    always_comb begin
        w_child     = r_code[r_bit] ? r_rd_data[19:10] : r_rd_data[9:0];
        w_is_leaf   = w_child[9];
        w_sym       = ~w_child;
        w_ended_now = w_is_leaf ? (w_sym[9:8] != 2'b00)
                                : (w_child[8:0] >= 9'(TREE_NODES));
        w_leaf_ok   = w_is_leaf && !w_ended_now;
        w_next_pos  = w_is_leaf ? '0 : w_child[NODE_W-1:0];
    end

    // run-length stage on a leaf symbol
    always_comb begin
        w_run_valid  = 1'b0;
        w_run_byte   = w_sym[7:0];
        w_run_copies = 8'd1;
        w_leaf_await = r_await;
        w_leaf_prev  = r_prev;
        if (w_leaf_ok) begin
            if (r_await) begin
                w_leaf_await = 1'b0;
                w_run_valid  = 1'b1;
                if (w_sym[7:0] == 8'd0) begin
                    w_run_byte = RLE_MARKER;
                end else begin
                    w_run_byte   = r_prev;
                    w_run_copies = (w_sym[7:0] > 8'd1) ? w_sym[7:0] - 8'd1 : 8'd1;
                end
            end else if (w_sym[7:0] == RLE_MARKER) begin
                w_leaf_await = 1'b1;
            end else begin
                w_leaf_prev = w_sym[7:0];
                w_run_valid = 1'b1;
            end
        end
        w_emit = w_run_valid && !(i_cfg.strip_cr && (w_run_byte == CR_BYTE));
        w_prod = {8'd0, w_run_byte} * {8'd0, w_run_copies};
    end

    always_comb begin
        n_state       = r_state;
        n_pos         = r_pos;
        n_prev        = r_prev;
        n_await       = r_await;
        n_sum         = r_sum;
        n_fin         = r_fin;
        n_bit         = r_bit;
        n_code        = r_code;
        n_ended       = r_ended;
        n_pend_valid  = r_pend_valid;
        n_pend_byte   = r_pend_byte;
        n_pend_copies = r_pend_copies;

        o_q_pop       = 1'b0;
        w_mem_we      = 1'b0;
        w_mem_waddr   = '0;
        w_mem_wdata   = END_NODE;
        w_mem_re      = 1'b0;
        w_mem_raddr   = r_pos;

        w_push        = 1'b0;
        w_push_byte   = r_pend_byte;
        w_push_copies = r_pend_copies;
        w_push_done   = 1'b0;
        w_push_ok     = 1'b0;
        w_push_last   = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    unique case (i_q_cmd.act)
                        ACT_START: begin
                            n_pos       = '0;
                            n_prev      = '0;
                            n_await     = 1'b0;
                            n_sum       = '0;
                            n_fin       = 1'b0;
                            w_mem_we    = 1'b1;
                            w_mem_waddr = '0;
                            w_mem_wdata = END_NODE;
                        end
                        ACT_LOAD: begin
                            if (!r_fin) begin
                                w_mem_we    = 1'b1;
                                w_mem_waddr = i_q_cmd.node_index[NODE_W-1:0];
                                w_mem_wdata = i_q_cmd.node;
                            end
                        end
                        ACT_CODE: begin
                            if (!r_fin) begin
                                w_mem_re    = 1'b1;
                                w_mem_raddr = r_pos;
                                n_code      = i_q_cmd.code;
                                n_bit       = '0;
                                n_ended     = 1'b0;
                                n_state     = S_WALK;
                            end
                        end
                        ACT_END: begin
                            if (!r_fin) begin
                                n_state = S_DONE;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_WALK: begin
                // hold the step while an older result cannot move out
                if (!(w_emit && r_pend_valid && !w_out_free)) begin
                    n_await = w_leaf_await;
                    n_prev  = w_leaf_prev;
                    if (w_run_valid) begin
                        n_sum = r_sum + w_prod;
                    end
                    if (w_emit) begin
                        if (r_pend_valid) begin
                            w_push      = 1'b1;
                            w_push_last = 1'b0;
                        end
                        n_pend_valid  = 1'b1;
                        n_pend_byte   = w_run_byte;
                        n_pend_copies = w_run_copies;
                    end
                    if (w_ended_now) begin
                        n_ended = 1'b1;
                        n_state = S_FLUSH;
                    end else if (r_bit == 3'd7) begin
                        n_pos   = w_next_pos;
                        n_state = S_FLUSH;
                    end else begin
                        w_mem_re    = 1'b1;
                        w_mem_raddr = w_next_pos;
                        n_bit       = r_bit + 3'd1;
                    end
                end
            end
            S_FLUSH: begin
                if (r_pend_valid) begin
                    if (w_out_free) begin
                        w_push       = 1'b1;
                        w_push_last  = !r_ended;
                        n_pend_valid = 1'b0;
                        n_state      = r_ended ? S_DONE : S_IDLE;
                    end
                end else begin
                    n_state = r_ended ? S_DONE : S_IDLE;
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    w_push        = 1'b1;
                    w_push_byte   = '0;
                    w_push_copies = '0;
                    w_push_done   = 1'b1;
                    w_push_ok     = (r_sum == i_cfg.expected);
                    w_push_last   = 1'b1;
                    n_fin         = 1'b1;
                    n_pos         = '0;
                    n_state       = S_IDLE;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem[w_mem_waddr] <= w_mem_wdata;
        end
        if (w_mem_re) begin
            r_rd_data <= r_mem[w_mem_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_pos        <= '0;
            r_prev       <= '0;
            r_await      <= 1'b0;
            r_sum        <= '0;
            r_fin        <= 1'b0;
            r_ended      <= 1'b0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_pos        <= n_pos;
            r_prev       <= n_prev;
            r_await      <= n_await;
            r_sum        <= n_sum;
            r_fin        <= n_fin;
            r_ended      <= n_ended;
            r_pend_valid <= n_pend_valid;
            if (w_push) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_bit         <= n_bit;
        r_code        <= n_code;
        r_pend_byte   <= n_pend_byte;
        r_pend_copies <= n_pend_copies;
        if (w_push) begin
            r_out_byte   <= w_push_byte;
            r_out_copies <= w_push_copies;
            r_out_done   <= w_push_done;
            r_out_ok     <= w_push_ok;
            r_out_last   <= w_push_last;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_out_byte    = r_out_byte;
    assign o_copies      = r_out_copies;
    assign o_done_res    = r_out_done;
    assign o_checksum_ok = r_out_ok;
    assign o_last        = r_out_last;

`ifndef ASSERT_OFF
    a_pend_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE || r_state == S_DONE) |-> !r_pend_valid)
        else $error("held result left over between items");
    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_pop |-> (r_state == S_IDLE))
        else $error("queue popped while busy");
    a_run_copies: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_done) |-> (r_out_copies != 8'd0 && !r_out_ok))
        else $error("run result with zero copies or a verdict");
    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push && w_push_done) |=> (r_fin && r_state == S_IDLE))
        else $error("done result without finishing");
`endif

endmodule

>>> rtl/huffman_tree_rle_unsqueezer_unit.sv
// squeezed stream decoder: huffman tree walk followed by 0x90 run-length expansion
//
// input channel (i_in_valid / o_in_stall): one beat is a start, a tree node load,
// a code byte or an end-of-input marker. beats go into a two-entry queue, so the
// sender can run up to two beats ahead while the decoder is busy or the receiver stalls.
// output channel (o_out_valid / i_out_stall): one beat is a run (byte and copy
// count) or the done beat with the checksum verdict; o_last marks the final beat
// caused by one input beat.
// config port: i_cfg_we writes i_cfg_index 0 (strip_cr) or 1 (expected checksum);
// the user must write only while the decoder is idle, the block does not enforce it.
// a start or load is handled in the idle state. a code byte goes through a tree
// read, up to eight bit steps and a flush, since each bit needs the node that
// the previous bit chose from the tree memory. an end (by token or marker) adds
// a done beat. the decoder pops the next queued beat only when back in idle.
// reset clears the queue, the decoder state and the config registers; the tree
// memory is not cleared and must be loaded after a start.
// a stalled receiver freezes the walk when a new result finds both the output
// register and the held result slot full; beats already on the output hold until taken.
module huffman_tree_rle_unsqueezer_unit import htrlu_pkg::*; #(
    parameter int TREE_NODES = 256
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // input channel
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [1:0]        i_action,
    input  logic [7:0]        i_node_index,
    input  logic signed [9:0] i_left_child,
    input  logic signed [9:0] i_right_child,
    input  logic [7:0]        i_code_byte,
    // output channel
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [7:0]        o_out_byte,
    output logic [7:0]        o_copies,
    output logic              o_done_res,
    output logic              o_checksum_ok,
    output logic              o_last,
    // configuration write port
    input  logic              i_cfg_we,
    input  logic              i_cfg_index,
    input  logic [15:0]       i_cfg_data
);

    // configuration registers
    logic        r_strip_cr;
    logic [15:0] r_expected;
    t_cfg        w_cfg;

    // queue between the front and the decoder
    logic w_q_valid, w_q_pop;
    t_cmd w_q_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strip_cr <= 1'b0;
            r_expected <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_STRIP_CR: r_strip_cr <= i_cfg_data[0];
                CFG_EXPECTED: r_expected <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign w_cfg.strip_cr = r_strip_cr;
    assign w_cfg.expected = r_expected;

    // front: takes beats, drops loads beyond the tree, queues the rest
    htrlu_front #(
        .TREE_NODES (TREE_NODES)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_action      (i_action),
        .i_node_index  (i_node_index),
        .i_left_child  (i_left_child),
        .i_right_child (i_right_child),
        .i_code_byte   (i_code_byte),
        .o_q_valid     (w_q_valid),
        .o_q_cmd       (w_q_cmd),
        .i_q_pop       (w_q_pop)
    );

    // back: tree memory, bit-serial walk, run-length stage, output register
    htrlu_back #(
        .TREE_NODES (TREE_NODES)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (w_cfg),
        .i_q_valid     (w_q_valid),
        .i_q_cmd       (w_q_cmd),
        .o_q_pop       (w_q_pop),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_out_byte    (o_out_byte),
        .o_copies      (o_copies),
        .o_done_res    (o_done_res),
        .o_checksum_ok (o_checksum_ok),
        .o_last        (o_last)
    );

endmodule

>>> sim/huffman_tree_rle_unsqueezer_unit_tb.sv
import htrlu_pkg::*;

localparam int TREE_SIZE  = 256;
localparam int END_SYMBOL = 256;

// one decoded run or the done beat, as seen on the output channel
typedef struct packed {
    logic [7:0] value;
    logic [7:0] copies;
    logic       done;
    logic       ok;
    logic       last;
} t_run;

class unsqueeze_scoreboard;
    logic [19:0] tree_mem [TREE_SIZE];
    logic [7:0]  walk_pos;
    logic [7:0]  prev_byte;
    bit          awaiting_count;
    bit          stream_done;
    bit          strip_cr;
    logic [15:0] run_sum;
    logic [15:0] expected_sum;
    t_run        runs_due[$];
    int          errors;
    int          runs_checked;

    function new();
        walk_pos       = '0;
        prev_byte      = '0;
        awaiting_count = 1'b0;
        stream_done    = 1'b0;
        strip_cr       = 1'b0;
        run_sum        = '0;
        expected_sum   = '0;
        errors         = 0;
        runs_checked   = 0;
    endfunction

    function void set_config(logic idx, logic [15:0] data);
        if (idx == CFG_STRIP_CR) begin
            strip_cr = data[0];
        end else begin
            expected_sum = data;
        end
    endfunction

    function void add_run(logic [7:0] value, logic [7:0] copies);
        t_run r;
        run_sum = run_sum + value * copies;
        if (value == CR_BYTE && strip_cr) begin
            return;
        end
        r = '0;
        r.value  = value;
        r.copies = copies;
        runs_due.push_back(r);
    endfunction

    function void end_stream();
        t_run r;
        stream_done = 1'b1;
        walk_pos    = '0;
        r      = '0;
        r.done = 1'b1;
        r.ok   = (run_sum == expected_sum);
        runs_due.push_back(r);
    endfunction

    function void take_symbol(int sym);
        if (awaiting_count) begin
            awaiting_count = 1'b0;
            if (sym == 0) begin
                add_run(RLE_MARKER, 8'd1);
            end else begin
                add_run(prev_byte, (sym > 1) ? 8'(sym - 1) : 8'd1);
            end
        end else if (sym == RLE_MARKER) begin
            awaiting_count = 1'b1;
        end else begin
            prev_byte = 8'(sym);
            add_run(8'(sym), 8'd1);
        end
    endfunction

    // works out the runs that one accepted input beat causes
    function void decode_beat(t_cmd c);
        int         first;
        int         child;
        int         sym;
        logic [7:0] pos;
        logic [9:0] raw;
        bit         ended;
        t_run       r;
        first = runs_due.size();
        if (c.act == ACT_START) begin
            walk_pos       = '0;
            prev_byte      = '0;
            awaiting_count = 1'b0;
            run_sum        = '0;
            stream_done    = 1'b0;
            tree_mem[0]    = END_NODE;
            return;
        end
        if (stream_done) begin
            return;
        end
        case (c.act)
            ACT_LOAD: tree_mem[c.node_index] = c.node;
            ACT_END:  end_stream();
            default: begin
                pos   = walk_pos;
                ended = 1'b0;
                for (int b = 0; b < 8 && !ended; b++) begin
                    raw   = c.code[b] ? tree_mem[pos][19:10] : tree_mem[pos][9:0];
                    child = $signed(raw);
                    if (child >= 0) begin
                        if (child >= TREE_SIZE) begin
                            ended = 1'b1;
                        end else begin
                            pos = 8'(child);
                        end
                    end else begin
                        sym = -(child + 1);
                        if (sym >= END_SYMBOL) begin
                            ended = 1'b1;
                        end else begin
                            pos = '0;
                            take_symbol(sym);
                        end
                    end
                end
                if (ended) begin
                    end_stream();
                end else begin
                    walk_pos = pos;
                end
            end
        endcase
        if (runs_due.size() > first) begin
            r = runs_due.pop_back();
            r.last = 1'b1;
            runs_due.push_back(r);
        end
    endfunction

    function void check_field(string name, longint stamp, logic [7:0] want, logic [7:0] got);
        if (got !== want) begin
            errors++;
            $display("%0t ns: %s expected %0h got %0h", stamp, name, want, got);
        end
    endfunction

    function void check_run(t_run got, longint stamp);
        t_run want;
        if (runs_due.size() == 0) begin
            errors++;
            $display("%0t ns: unexpected beat, byte %0h copies %0d done %0b",
                     stamp, got.value, got.copies, got.done);
            return;
        end
        want = runs_due.pop_front();
        runs_checked++;
        check_field("out_byte", stamp, want.value, got.value);
        check_field("copies", stamp, want.copies, got.copies);
        check_field("done_res", stamp, 8'(want.done), 8'(got.done));
        check_field("checksum_ok", stamp, 8'(want.ok), 8'(got.ok));
        check_field("last", stamp, 8'(want.last), 8'(got.last));
    endfunction
endclass

module huffman_tree_rle_unsqueezer_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LONG_HOLD     = 400;   // receiver hold-off that fills the block
    localparam int SETTLE_CYCLES = 48;    // two queued code bytes plus one in flight
    localparam int RANDOM_BEATS  = 150;
    localparam int CHAIN_END     = 6;     // position of the end token in the directed tree

    logic              i_clk;
    logic              i_rst_n;
    logic              i_in_valid;
    logic              o_in_stall;
    logic [1:0]        i_action;
    logic [7:0]        i_node_index;
    logic signed [9:0] i_left_child;
    logic signed [9:0] i_right_child;
    logic [7:0]        i_code_byte;
    logic              o_out_valid;
    logic              i_out_stall;
    logic [7:0]        o_out_byte;
    logic [7:0]        o_copies;
    logic              o_done_res;
    logic              o_checksum_ok;
    logic              o_last;
    logic              i_cfg_we;
    logic              i_cfg_index;
    logic [15:0]       i_cfg_data;

    huffman_tree_rle_unsqueezer_unit i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_action      (i_action),
        .i_node_index  (i_node_index),
        .i_left_child  (i_left_child),
        .i_right_child (i_right_child),
        .i_code_byte   (i_code_byte),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_out_byte    (o_out_byte),
        .o_copies      (o_copies),
        .o_done_res    (o_done_res),
        .o_checksum_ok (o_checksum_ok),
        .o_last        (o_last),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    unsqueeze_scoreboard sb;
    t_run seen_run;
    int   live_beats;
    int   random_goal;
    int   streams_run;
    int   cfg_writes;
    int   hold_requests;
    int   holds_served;
    bit   gap_free;
    bit   node_used [TREE_SIZE];
    t_cmd tree_loads[$];
    int   chain_path[$];

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // give up well past the slowest legal run
    initial begin
        #5_000_000;
        $display("[huffman_tree_rle_unsqueezer_unit] ERROR");
        $finish;
    end

    // output side: every accepted beat goes straight to the scoreboard
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            seen_run = {o_out_byte, o_copies, o_done_res, o_checksum_ok, o_last};
            sb.check_run(seen_run, $time);
        end
    end

    // receiver stall pattern: segments of no stall, light and heavy random stall,
    // and rare long stretches; a pending hold request wins over all of them
    initial begin
        int seg;
        int mode;
        i_out_stall = 1'b0;
        forever begin
            seg  = $urandom_range(16, 64);
            mode = $urandom_range(0, 3);
            repeat (seg) begin
                @(negedge i_clk);
                if (hold_requests != holds_served) begin
                    holds_served++;
                    i_out_stall = 1'b1;
                    repeat (LONG_HOLD) @(negedge i_clk);
                end else begin
                    case (mode)
                        0: i_out_stall = 1'b0;
                        1: i_out_stall = ($urandom_range(0, 3) == 0);
                        2: i_out_stall = ($urandom_range(0, 1) == 0);
                        default: begin
                            if ($urandom_range(0, 19) == 0) begin
                                i_out_stall = 1'b1;
                                repeat ($urandom_range(10, 40)) @(negedge i_clk);
                            end else begin
                                i_out_stall = 1'b0;
                            end
                        end
                    endcase
                end
            end
        end
    end

    // sender gap: mostly back to back, sometimes short, rarely long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (gap_free || r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [9:0] leaf_code(int sym);
        return 10'(-(sym + 1));
    endfunction

    // any child value in the legal range, leaf or index
    function automatic logic [9:0] rand_child();
        return 10'(int'($urandom_range(0, 512)) - 257);
    endfunction

    // fields that the action does not use carry junk
    function automatic t_cmd make_beat(logic [1:0] act);
        t_cmd c;
        c.act        = act;
        c.node_index = 8'($urandom);
        c.node       = {rand_child(), rand_child()};
        c.code       = 8'($urandom);
        return c;
    endfunction

    function automatic t_cmd load_beat(int idx, logic [9:0] left, logic [9:0] right);
        t_cmd c;
        c = make_beat(ACT_LOAD);
        c.node_index = 8'(idx);
        c.node       = {right, left};
        return c;
    endfunction

    // leaf symbols weighted toward the marker, carriage return and tiny counts
    function automatic int pick_symbol();
        int r;
        r = $urandom_range(0, 99);
        if (r < 25) return RLE_MARKER;
        if (r < 35) return CR_BYTE;
        if (r < 50) return $urandom_range(0, 2);
        if (r < 55) return 255;
        return $urandom_range(0, 255);
    endfunction

    task automatic send_beat(t_cmd c);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            @(negedge i_clk);
            i_in_valid = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_action      = c.act;
        i_node_index  = c.node_index;
        i_left_child  = c.node[9:0];
        i_right_child = c.node[19:10];
        i_code_byte   = c.code;
        i_in_valid    = 1'b1;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        // beats swallowed after the done beat do not count
        if (c.act == ACT_START || !sb.stream_done) live_beats++;
        sb.decode_beat(c);
    endtask

    // sender goes quiet until every run has come back and the decoder is idle
    task automatic settle();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (sb.runs_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic [15:0] data);
        @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        sb.set_config(idx, data);
        cfg_writes++;
    endtask

    // packs chain_path codes lsb first into code bytes, zero padded;
    // in the directed tree position k is k ones then a zero, the end token six ones
    task automatic send_chain();
        bit         bits[$];
        logic [7:0] code;
        t_cmd       c;
        foreach (chain_path[k]) begin
            repeat (chain_path[k]) bits.push_back(1'b1);
            if (chain_path[k] < CHAIN_END) bits.push_back(1'b0);
        end
        while (bits.size() % 8 != 0) bits.push_back(1'b0);
        while (bits.size() != 0) begin
            for (int b = 0; b < 8; b++) code[b] = bits.pop_front();
            c = make_beat(ACT_CODE);
            c.code = code;
            send_beat(c);
        end
    endtask

    // random full binary tree rooted at node 0, internal nodes at random indexes
    task automatic grow_tree(int n_leaves, bit with_end);
        logic [9:0] pool[$];
        int         free_idx[$];
        logic [9:0] a;
        logic [9:0] b;
        int         k;
        int         idx;
        foreach (node_used[n]) node_used[n] = 1'b0;
        node_used[0] = 1'b1;
        tree_loads.delete();
        for (k = 0; k < n_leaves; k++) pool.push_back(leaf_code(pick_symbol()));
        if (with_end) pool[$urandom_range(0, pool.size() - 1)] = END_CHILD;
        for (k = 1; k < TREE_SIZE; k++) free_idx.push_back(k);
        while (pool.size() > 1) begin
            k = $urandom_range(0, pool.size() - 1);
            a = pool[k];
            pool.delete(k);
            k = $urandom_range(0, pool.size() - 1);
            b = pool[k];
            pool.delete(k);
            if (pool.size() == 0) begin
                idx = 0;
            end else begin
                k   = $urandom_range(0, free_idx.size() - 1);
                idx = free_idx[k];
                free_idx.delete(k);
            end
            node_used[idx] = 1'b1;
            tree_loads.push_back(load_beat(idx, a, b));
            pool.push_back(10'(idx));
        end
    endtask

    // one random stream: config, start, tree, code bytes, end, swallowed tail
    task automatic run_stream(bit with_hold);
        int   n_leaves;
        int   n_codes;
        int   k;
        int   idx;
        bit   with_end;
        bit   match_sum;
        t_cmd c;
        n_leaves  = ($urandom_range(0, 9) == 0) ? $urandom_range(12, 48)
                                                : $urandom_range(2, 10);
        with_end  = !with_hold && ($urandom_range(0, 9) < 6);
        n_codes   = with_hold ? 16 : $urandom_range(2, 14);
        match_sum = $urandom_range(0, 1);
        grow_tree(n_leaves, with_end);
        settle();
        gap_free = ($urandom_range(0, 3) == 0);
        write_reg(CFG_STRIP_CR, 16'($urandom_range(0, 1)));
        case ($urandom_range(0, 3))
            0:       write_reg(CFG_EXPECTED, 16'h0000);
            1:       write_reg(CFG_EXPECTED, 16'hFFFF);
            default: write_reg(CFG_EXPECTED, 16'($urandom));
        endcase
        send_beat(make_beat(ACT_START));
        while (tree_loads.size() != 0) begin
            // stray load to a node outside this tree
            if ($urandom_range(0, 7) == 0) begin
                do idx = $urandom_range(1, TREE_SIZE - 1); while (node_used[idx]);
                send_beat(load_beat(idx, rand_child(), rand_child()));
            end
            k = $urandom_range(0, tree_loads.size() - 1);
            c = tree_loads[k];
            tree_loads.delete(k);
            send_beat(c);
        end
        if (with_hold) hold_requests++;
        for (k = 0; k < n_codes && !sb.stream_done; k++) begin
            send_beat(make_beat(ACT_CODE));
        end
        // now and then the stream is cut short by the next start
        if (!sb.stream_done && $urandom_range(0, 9) != 0) begin
            if (match_sum) begin
                settle();
                write_reg(CFG_EXPECTED, sb.run_sum);
            end
            send_beat(make_beat(ACT_END));
        end
        if (sb.stream_done) begin
            repeat ($urandom_range(0, 2)) send_beat(make_beat(2'($urandom_range(1, 3))));
        end
        streams_run++;
    endtask

    initial begin
        sb            = new();
        live_beats    = 0;
        streams_run   = 0;
        cfg_writes    = 0;
        hold_requests = 0;
        holds_served  = 0;
        gap_free      = 1'b0;
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_action      = ACT_START;
        i_node_index  = '0;
        i_left_child  = '0;
        i_right_child = '0;
        i_code_byte   = '0;
        i_cfg_we      = 1'b0;
        i_cfg_index   = CFG_STRIP_CR;
        i_cfg_data    = '0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // input end straight after reset, empty sum against a zero register
        send_beat(make_beat(ACT_END));
        // fresh start: node 0 holds only end tokens, so any code byte ends at once
        send_beat(make_beat(ACT_START));
        send_beat(make_beat(ACT_CODE));
        // all of these are swallowed after the done beat
        send_beat(make_beat(ACT_CODE));
        send_beat(make_beat(ACT_LOAD));
        send_beat(make_beat(ACT_END));

        settle();
        write_reg(CFG_STRIP_CR, 16'h0000);
        write_reg(CFG_EXPECTED, 16'hFFFF);
        // chain tree: 'A', marker, cr, 0, 1, 255, end token at growing depth
        send_beat(make_beat(ACT_START));
        send_beat(load_beat(0, leaf_code(8'h41), 10'd1));
        send_beat(load_beat(1, leaf_code(RLE_MARKER), 10'd2));
        send_beat(load_beat(2, leaf_code(CR_BYTE), 10'd3));
        send_beat(load_beat(3, leaf_code(0), 10'd4));
        send_beat(load_beat(4, leaf_code(1), 10'd255));
        send_beat(load_beat(255, leaf_code(255), END_CHILD));
        // literal, escaped marker, 254 copies, the one-copy quirk, cr kept,
        // codes running across byte borders
        chain_path = {0, 1, 3, 1, 5, 1, 4, 2, 0};
        send_chain();
        settle();
        write_reg(CFG_EXPECTED, sb.run_sum);
        send_beat(make_beat(ACT_END));

        settle();
        write_reg(CFG_STRIP_CR, 16'h0001);
        // restart reuses nodes 1 to 4 and 255; cr dropped but summed, end token while a
        // count is pending, padding after the token ignored
        send_beat(make_beat(ACT_START));
        send_beat(load_beat(0, leaf_code(8'h41), 10'd1));
        chain_path = {2, 1, CHAIN_END};
        send_chain();

        // random streams; the second one carries the long receiver hold
        random_goal = live_beats + RANDOM_BEATS;
        while (live_beats < random_goal) run_stream(streams_run == 1);

        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (sb.runs_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("covered %0d live input beats: directed chain tree plus %0d random streams",
                 live_beats, streams_run);
        $display("%0d output beats checked, %0d register writes, %0d long output holds",
                 sb.runs_checked, cfg_writes, holds_served);
        if (sb.errors == 0 && sb.runs_due.size() == 0) begin
            $display("[huffman_tree_rle_unsqueezer_unit] OK");
        end else begin
            $display("[huffman_tree_rle_unsqueezer_unit] ERROR");
        end
        $finish;
    end
endmodule

>>> filelist.f
rtl/htrlu_pkg.sv
rtl/htrlu_front.sv
rtl/htrlu_back.sv
rtl/huffman_tree_rle_unsqueezer_unit.sv
sim/huffman_tree_rle_unsqueezer_unit_tb.sv
